// ===== rtl/prrs_pkg.sv =====
package prrs_pkg;

	localparam int MAX_THREADS  = 64;
	localparam int MAX_PRIORITY = 5;
	localparam int MAX_EVENTS   = 256;

	localparam int THR_W  = $clog2(MAX_THREADS);
	localparam int CNT_W  = THR_W + 1;
	localparam int PRIO_W = 3;
	localparam int EVN_W  = 8;
	localparam int EVC_W  = 9;
	localparam int TQ_W   = 16;
	localparam int CMD_W  = 3;
	localparam int RES_W  = 7;
	localparam int STAT_W = 2;
	localparam int OTHR_W = 6;

	localparam logic [CMD_W-1:0] CMD_FORK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_EXEC   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WAIT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SIGNAL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FINISH = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INVAL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	localparam logic CFG_QUANTUM = 1'b0;
	localparam logic CFG_EVENTS  = 1'b1;

	// thread table entry: waiting flag, priority, awaited event
	typedef struct packed {
		logic              waiting;
		logic [PRIO_W-1:0] prio;
		logic [EVN_W-1:0]  evt;
	} thr_ent_t;

	// ready queue entry carries its priority alongside the thread index
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [THR_W-1:0]  thr;
	} rq_ent_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INS_RD, S_INS, S_TICK, S_TICK_CHK,
		S_HEAD_RD, S_HEAD, S_SCAN_RD, S_SCAN, S_DONE
	} sched_state_t;

	typedef enum logic [1:0] {RET_TICK, RET_SCAN, RET_HEAD} ins_ret_t;

endpackage

// ===== rtl/prrs_req_if.sv =====
interface prrs_req_if;
	import prrs_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [PRIO_W-1:0] priority_req;
	logic [EVN_W-1:0]  event_number;
	modport source (output valid, command, priority_req, event_number, input ready);
	modport sink (input valid, command, priority_req, event_number, output ready);
endinterface

// ===== rtl/prrs_rsp_if.sv =====
interface prrs_rsp_if;
	import prrs_pkg::*;
	logic              valid;
	logic              ready;
	logic [OTHR_W-1:0] running_thread;
	logic              running_valid;
	logic [RES_W-1:0]  result_value;
	logic [STAT_W-1:0] status;
	modport source (output valid, running_thread, running_valid, result_value, status,
		input ready);
	modport sink (input valid, running_thread, running_valid, result_value, status,
		output ready);
endinterface

// ===== rtl/prrs_cfg_if.sv =====
interface prrs_cfg_if;
	import prrs_pkg::*;
	logic            valid;
	logic            ready;
	logic            index;
	logic [TQ_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/prrs_ram.sv =====
module prrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/priority_round_robin_scheduler.sv =====
// Priority round-robin thread scheduler.
// Commands arrive on req (fork, exec tick, wait, signal, finish); each one
// gives exactly one beat on rsp with the running thread, the forked index
// or woken count, and a status. Registers are written on cfg (index 0 time
// quantum, index 1 event count); cfg is always ready and is to be written
// only while the scheduler is idle; the block itself does not enforce this.
// A rejected command or a simple fork goes straight to the response. A tick
// spends a quantum unit and checks the queue head, and after an ordered
// insert pops the new head when it preempts or rotates; every ordered insert
// into the ready queue reads the tail and shifts back each entry it passes;
// a signal scans every thread in the table plus one insert per woken thread.
// Table and ready queue memories: one write, one registered read port each.
// req.ready is high only while the sequencer is idle. The result sits in an
// output register, so the next command is taken while it waits; if rsp
// stalls, the following command holds at its end until the register frees.
// Reset empties the ready queue and the table count and leaves the
// processor idle; the time quantum returns to 1 and the event count to 0.
module priority_round_robin_scheduler import prrs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	prrs_req_if.sink   req,
	prrs_rsp_if.source rsp,
	prrs_cfg_if.sink   cfg
);

	sched_state_t      state_q, state_d;
	ins_ret_t          ret_q, ret_d;
	logic [CNT_W-1:0]  len_q, len_d, total_q, total_d, pos_q, pos_d, idx_q, idx_d;
	logic [THR_W-1:0]  head_q, head_d, cur_q, cur_d, ins_thr_q, ins_thr_d;
	logic              present_q, present_d, cur_wait_q, cur_wait_d;
	logic [PRIO_W-1:0] cur_prio_q, cur_prio_d, ins_prio_q, ins_prio_d;
	logic [TQ_W-1:0]   quant_q, quant_d, tq_q, qdec;
	logic [EVC_W-1:0]  evc_q;
	logic [EVN_W-1:0]  ev_q, ev_d;
	logic [RES_W-1:0]  res_q, res_d;
	logic [STAT_W-1:0] stat_q, stat_d;
	logic              rsp_valid_q, rsp_valid_d, load_out;

	logic              tb_we, rq_we;
	logic [THR_W-1:0]  tb_waddr, tb_raddr, rq_waddr, rq_raddr;
	thr_ent_t          tb_wdata, tb_rdata;
	rq_ent_t           rq_wdata, rq_rdata;

	prrs_ram #(.WIDTH($bits(thr_ent_t)), .DEPTH(MAX_THREADS)) u_table (
		.clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
		.raddr(tb_raddr), .rdata(tb_rdata)
	);

	prrs_ram #(.WIDTH($bits(rq_ent_t)), .DEPTH(MAX_THREADS)) u_rqueue (
		.clk(clk), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
		.raddr(rq_raddr), .rdata(rq_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign qdec = (quant_q != '0) ? quant_q - TQ_W'(1) : '0;

	function automatic sched_state_t ret_state(input ins_ret_t r);
		case (r)
			RET_TICK: ret_state = S_TICK;
			RET_SCAN: ret_state = S_SCAN_RD;
			default:  ret_state = S_HEAD_RD;
		endcase
	endfunction

	// sequencer: next state and datapath updates
	always_comb begin
		state_d = state_q; ret_d = ret_q; len_d = len_q; total_d = total_q;
		pos_d = pos_q; idx_d = idx_q; head_d = head_q; cur_d = cur_q;
		ins_thr_d = ins_thr_q; present_d = present_q; cur_wait_d = cur_wait_q;
		cur_prio_d = cur_prio_q; ins_prio_d = ins_prio_q; quant_d = quant_q;
		ev_d = ev_q; res_d = res_q; stat_d = stat_q;
		load_out = 1'b0;
		tb_we = 1'b0; tb_waddr = cur_q; tb_wdata = '0; tb_raddr = idx_q[THR_W-1:0];
		rq_we = 1'b0; rq_waddr = head_q; rq_wdata = '0; rq_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					res_d = '0;
					stat_d = STAT_OK;
					ev_d = req.event_number;
					state_d = S_DONE;
					case (req.command)
						CMD_FORK: begin
							if (req.priority_req > PRIO_W'(MAX_PRIORITY)) begin
								stat_d = STAT_INVAL;
							end else if (total_q >= CNT_W'(MAX_THREADS)) begin
								stat_d = STAT_FULL;
							end else begin
								tb_we = 1'b1;
								tb_waddr = total_q[THR_W-1:0];
								tb_wdata = '{waiting: 1'b0, prio: req.priority_req, evt: '0};
								res_d = RES_W'(total_q);
								total_d = total_q + CNT_W'(1);
								if (!present_q) begin
									cur_d = total_q[THR_W-1:0];
									cur_prio_d = req.priority_req;
									present_d = 1'b1;
									cur_wait_d = 1'b0;
									quant_d = tq_q;
								end else begin
									ins_prio_d = req.priority_req;
									ins_thr_d = total_q[THR_W-1:0];
									ret_d = RET_TICK;
									state_d = S_INS_RD;
								end
							end
						end
						CMD_EXEC: begin
							if (!present_q) stat_d = STAT_INVAL;
							else state_d = S_TICK;
						end
						CMD_FINISH: begin
							if (!present_q) stat_d = STAT_INVAL;
							else if (len_q != '0) state_d = S_HEAD_RD;
							else present_d = 1'b0;
						end
						CMD_WAIT, CMD_SIGNAL: begin
							if (!present_q || EVC_W'(req.event_number) >= evc_q) begin
								stat_d = STAT_INVAL;
							end else if (req.command == CMD_WAIT) begin
								tb_we = 1'b1;
								tb_waddr = cur_q;
								tb_wdata = '{waiting: 1'b1, prio: cur_prio_q,
									evt: req.event_number};
								cur_wait_d = 1'b1;
								state_d = S_TICK;
							end else begin
								idx_d = '0;
								state_d = S_SCAN_RD;
							end
						end
						default: stat_d = STAT_INVAL;
					endcase
				end
			end
			// start an ordered insert at the tail
			S_INS_RD: begin
				if (len_q >= CNT_W'(MAX_THREADS)) begin
					state_d = ret_state(ret_q);
				end else begin
					rq_raddr = head_q + len_q[THR_W-1:0] - THR_W'(1);
					pos_d = len_q;
					state_d = S_INS;
				end
			end
			// shift lower-priority entries back one slot, then drop the new one in
			S_INS: begin
				rq_we = 1'b1;
				rq_waddr = head_q + pos_q[THR_W-1:0];
				if (pos_q != '0 && rq_rdata.prio < ins_prio_q) begin
					rq_wdata = rq_rdata;
					pos_d = pos_q - CNT_W'(1);
					rq_raddr = head_q + pos_q[THR_W-1:0] - THR_W'(2);
				end else begin
					rq_wdata = '{prio: ins_prio_q, thr: ins_thr_q};
					len_d = len_q + CNT_W'(1);
					state_d = ret_state(ret_q);
				end
			end
			// spend one quantum unit, fetch the queue head
			S_TICK: begin
				quant_d = qdec;
				if (len_q == '0) begin
					if (cur_wait_q) begin
						present_d = 1'b0;
						cur_wait_d = 1'b0;
					end else begin
						quant_d = tq_q;
					end
					state_d = S_DONE;
				end else begin
					state_d = S_TICK_CHK;
				end
			end
			// replace a waiting thread, or preempt, rotate or keep the running thread
			S_TICK_CHK: begin
				state_d = S_DONE;
				if (cur_wait_q) begin
					cur_d = rq_rdata.thr; cur_prio_d = rq_rdata.prio;
					present_d = 1'b1; cur_wait_d = 1'b0; quant_d = tq_q;
					head_d = head_q + THR_W'(1); len_d = len_q - CNT_W'(1);
				end else if (cur_prio_q < rq_rdata.prio ||
						(quant_q == '0 && cur_prio_q == rq_rdata.prio)) begin
					ins_prio_d = cur_prio_q;
					ins_thr_d = cur_q;
					ret_d = RET_HEAD;
					state_d = S_INS_RD;
				end else if (quant_q == '0) begin
					quant_d = tq_q;
				end
			end
			S_HEAD_RD: state_d = S_HEAD;
			// pop the queue head onto the processor
			S_HEAD: begin
				cur_d = rq_rdata.thr; cur_prio_d = rq_rdata.prio;
				present_d = 1'b1; cur_wait_d = 1'b0; quant_d = tq_q;
				head_d = head_q + THR_W'(1); len_d = len_q - CNT_W'(1);
				state_d = S_DONE;
			end
			// walk the thread table for waiters on the signaled event
			S_SCAN_RD: begin
				state_d = (idx_q >= total_q) ? S_TICK : S_SCAN;
			end
			S_SCAN: begin
				idx_d = idx_q + CNT_W'(1);
				state_d = S_SCAN_RD;
				if (tb_rdata.waiting && tb_rdata.evt == ev_q) begin
					tb_we = 1'b1;
					tb_waddr = idx_q[THR_W-1:0];
					tb_wdata = '{waiting: 1'b0, prio: tb_rdata.prio, evt: tb_rdata.evt};
					res_d = res_q + RES_W'(1);
					ins_prio_d = tb_rdata.prio;
					ins_thr_d = idx_q[THR_W-1:0];
					ret_d = RET_SCAN;
					state_d = S_INS_RD;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		rsp_valid_d = load_out | (rsp_valid_q & ~rsp.ready);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= RET_TICK;
			len_q <= '0;
			total_q <= '0;
			head_q <= '0;
			cur_q <= '0;
			present_q <= 1'b0;
			cur_wait_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			tq_q <= TQ_W'(1);
			evc_q <= '0;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
			len_q <= len_d;
			total_q <= total_d;
			head_q <= head_d;
			cur_q <= cur_d;
			present_q <= present_d;
			cur_wait_q <= cur_wait_d;
			rsp_valid_q <= rsp_valid_d;
			// register writes: clamp zero quantum and oversized event count
			if (cfg.valid) begin
				case (cfg.index)
					CFG_QUANTUM: tq_q <= (cfg.data == '0) ? TQ_W'(1) : cfg.data;
					CFG_EVENTS: evc_q <= (cfg.data[EVC_W-1:0] > EVC_W'(MAX_EVENTS)) ?
						EVC_W'(MAX_EVENTS) : cfg.data[EVC_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath and output registers
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		idx_q <= idx_d;
		ins_thr_q <= ins_thr_d;
		ins_prio_q <= ins_prio_d;
		cur_prio_q <= cur_prio_d;
		quant_q <= quant_d;
		ev_q <= ev_d;
		res_q <= res_d;
		stat_q <= stat_d;
		if (load_out) begin
			rsp.running_thread <= present_q ? OTHR_W'(cur_q) : '0;
			rsp.running_valid <= present_q;
			rsp.result_value <= res_q;
			rsp.status <= stat_q;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(MAX_THREADS)) else $error("ready queue overflow");
	a_len_total: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= total_q) else $error("ready queue longer than thread table");
	a_idle_nowait: assert property (@(posedge clk) disable iff (!arst_n)
		!present_q |-> !cur_wait_q) else $error("waiting flag without running thread");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req.valid) |=> (state_q != S_IDLE))
		else $error("accepted command not started");

endmodule
